>>> rtl/core/ssb_pkg.sv
package ssb_pkg;

  localparam int MAP_BITS_DEF = 1024;

  localparam int CMD_W    = 2;
  localparam int SERIAL_W = 16;
  localparam int STATUS_W = 2;
  localparam int FIRST_W  = 10;
  localparam int SIZE_W   = 11;
  localparam int WORD_W   = 8;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 2;

  localparam logic [SIZE_W-1:0] TRACK_SIZE_RST = 11'd1024;

  // commands
  localparam logic [CMD_W-1:0] CMD_TEST = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MARK = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FIND = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd2;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                bit_set;
    logic [FIRST_W-1:0]  first_clear;
    logic                all_set;
  } res_t;

endpackage

>>> rtl/core/sequence_seen_bitmap_top.sv
// test/mark: one word read-modify-write; the word read is registered, then the result strobe is registered out of ST_TM
// errors and the unused command: result strobe registered at the accepting edge, no busy
// find: one word read per cycle, at most (MAP_BITS+7)/8 words scanned
// the single memory port holds busy while a test/mark item is in ST_TM, so the next item waits
// reset: clearing pass over all (MAP_BITS+7)/8 words, busy high; results cannot be stalled
module sequence_seen_bitmap_top #(
  parameter int MAP_BITS = ssb_pkg::MAP_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  logic [ssb_pkg::CMD_W-1:0]     in_cmd,
  input  logic [ssb_pkg::SERIAL_W-1:0]  in_serial,
  // result channel, one beat per strobe
  output logic                          out_strobe,
  output logic [ssb_pkg::STATUS_W-1:0]  out_status,
  output logic                          out_bit_set,
  output logic [ssb_pkg::FIRST_W-1:0]   out_first_clear,
  output logic                          out_all_set,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ssb_pkg::APB_AW-1:0]    paddr,
  input  logic [ssb_pkg::APB_DW-1:0]    pwdata,
  output logic [ssb_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  // one byte per eight serials
  localparam int DEPTH = (MAP_BITS + 7) / 8;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // effective size holds 0..MAP_BITS
  localparam int SZW   = $clog2(MAP_BITS + 1);
  localparam int CW    = (SZW > ssb_pkg::SIZE_W) ? SZW : ssb_pkg::SIZE_W;

  logic [ssb_pkg::SIZE_W-1:0]  track_size_r;
  logic [SZW-1:0]              size_eff;
  logic                        cfg_wr;
  ssb_pkg::res_t               res;
  logic                        mem_en;
  logic                        mem_we;
  logic [AW-1:0]               mem_addr;
  logic [ssb_pkg::WORD_W-1:0]  mem_wdata;
  logic [ssb_pkg::WORD_W-1:0]  mem_rdata;

  // the size register is the only one, so every byte address in the window maps to it
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = ssb_pkg::APB_DW'(track_size_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      track_size_r <= ssb_pkg::TRACK_SIZE_RST;
    end else if (cfg_wr) begin
      track_size_r <= pwdata[ssb_pkg::SIZE_W-1:0];
    end
  end

  // sizes beyond the store are clamped to its capacity
  assign size_eff = (CW'(track_size_r) > CW'(MAP_BITS)) ? SZW'(MAP_BITS) : SZW'(track_size_r);

  ssb_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .SZW   (SZW)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .cmd          (in_cmd),
    .serial       (in_serial),
    .size_eff     (size_eff),
    .busy         (busy),
    .out_strobe_r (out_strobe),
    .res_r        (res),
    .mem_en       (mem_en),
    .mem_we       (mem_we),
    .mem_addr     (mem_addr),
    .mem_wdata    (mem_wdata),
    .mem_rdata    (mem_rdata)
  );

  // bit store, serial 8k+0 in bit 7 of word k
  ssb_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .en      (mem_en),
    .we      (mem_we),
    .addr    (mem_addr),
    .wdata   (mem_wdata),
    .rdata_r (mem_rdata)
  );

  assign out_status      = res.status;
  assign out_bit_set     = res.bit_set;
  assign out_first_clear = res.first_clear;
  assign out_all_set     = res.all_set;

endmodule

>>> rtl/core/ssb_mem.sv
module ssb_mem #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic                        we,
  input  logic [AW-1:0]               addr,
  input  logic [ssb_pkg::WORD_W-1:0]  wdata,
  output logic [ssb_pkg::WORD_W-1:0]  rdata_r
);

  logic [ssb_pkg::WORD_W-1:0] store_r [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        store_r[addr] <= wdata;
      end else begin
        rdata_r <= store_r[addr];
      end
    end
  end

endmodule

>>> rtl/core/ssb_ctrl.sv
module ssb_ctrl #(
  parameter int DEPTH = 128,
  parameter int AW    = 7,
  parameter int SZW   = 11
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ssb_pkg::CMD_W-1:0]     cmd,
  input  logic [ssb_pkg::SERIAL_W-1:0]  serial,
  input  logic [SZW-1:0]                size_eff,
  output logic                          busy,
  output logic                          out_strobe_r,
  output ssb_pkg::res_t                 res_r,
  output logic                          mem_en,
  output logic                          mem_we,
  output logic [AW-1:0]                 mem_addr,
  output logic [ssb_pkg::WORD_W-1:0]    mem_wdata,
  input  logic [ssb_pkg::WORD_W-1:0]    mem_rdata
);

  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_TM   = 2'd2;
  localparam logic [1:0] ST_SCAN = 2'd3;

  localparam int CW  = (ssb_pkg::SERIAL_W > SZW) ? ssb_pkg::SERIAL_W : SZW;
  localparam int BW0 = (AW + 3 > SZW) ? AW + 3 : SZW;
  localparam int BW  = ((BW0 > ssb_pkg::FIRST_W) ? BW0 : ssb_pkg::FIRST_W) + 1;

  logic [1:0]           state_r, state_nxt;
  logic [AW-1:0]        addr_r, addr_nxt;
  logic                 is_mark_r, is_mark_nxt;
  logic [2:0]           sel_r, sel_nxt;
  logic                 out_strobe_nxt;
  ssb_pkg::res_t        res_nxt;

  logic                 in_range;
  logic                 size_zero;
  logic [ssb_pkg::WORD_W-1:0] bit_mask;
  logic [BW-1:0]        base;
  logic [BW-1:0]        size_b;
  logic [7:0]           hit;
  logic                 any_hit;
  logic [2:0]           hit_idx;
  logic                 last_word;
  logic [BW-1:0]        pos;

  assign busy      = (state_r != ST_IDLE);
  assign in_range  = CW'(serial) < CW'(size_eff);
  assign size_zero = (size_eff == '0);
  // serial 8k+0 sits in bit 7 of word k
  assign bit_mask  = ssb_pkg::WORD_W'(8'h80) >> sel_r;

  // scan window over the word just read
  assign base      = BW'({addr_r, 3'b000});
  assign size_b    = BW'(size_eff);
  assign last_word = (base + BW'(ssb_pkg::WORD_W)) >= size_b;

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      hit[j] = ((base + BW'(j)) < size_b) && !mem_rdata[ssb_pkg::WORD_W-1-j];
    end
  end

  always_comb begin
    hit_idx = 3'd0;
    for (int j = 7; j >= 0; j--) begin
      if (hit[j]) begin
        hit_idx = 3'(j);
      end
    end
  end

  assign any_hit = |hit;
  assign pos     = BW'({addr_r, hit_idx});

  always_comb begin
    state_nxt      = state_r;
    addr_nxt       = addr_r;
    is_mark_nxt    = is_mark_r;
    sel_nxt        = sel_r;
    out_strobe_nxt = 1'b0;
    res_nxt        = res_r;
    mem_en         = 1'b0;
    mem_we         = 1'b0;
    mem_addr       = addr_r;
    mem_wdata      = '0;
    case (state_r)
      ST_CLR: begin
        mem_en = 1'b1;
        mem_we = 1'b1;
        if (addr_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
          addr_nxt  = '0;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (start) begin
          res_nxt     = '0;
          is_mark_nxt = (cmd == ssb_pkg::CMD_MARK);
          sel_nxt     = serial[2:0];
          case (cmd)
            ssb_pkg::CMD_TEST, ssb_pkg::CMD_MARK: begin
              if (size_zero) begin
                out_strobe_nxt = 1'b1;
                res_nxt.status = ssb_pkg::STATUS_INVALID;
              end else if (!in_range) begin
                out_strobe_nxt = 1'b1;
                res_nxt.status = ssb_pkg::STATUS_RANGE;
              end else begin
                mem_en    = 1'b1;
                mem_addr  = serial[AW+2:3];
                addr_nxt  = serial[AW+2:3];
                state_nxt = ST_TM;
              end
            end
            ssb_pkg::CMD_FIND: begin
              if (size_zero) begin
                out_strobe_nxt = 1'b1;
                res_nxt.status = ssb_pkg::STATUS_INVALID;
              end else begin
                mem_en    = 1'b1;
                mem_addr  = '0;
                addr_nxt  = '0;
                state_nxt = ST_SCAN;
              end
            end
            default: begin
              out_strobe_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_TM: begin
        out_strobe_nxt = 1'b1;
        state_nxt      = ST_IDLE;
        if (is_mark_r) begin
          mem_en          = 1'b1;
          mem_we          = 1'b1;
          mem_wdata       = mem_rdata | bit_mask;
          res_nxt.bit_set = 1'b1;
        end else begin
          res_nxt.bit_set = |(mem_rdata & bit_mask);
        end
      end
      ST_SCAN: begin
        if (any_hit) begin
          out_strobe_nxt      = 1'b1;
          res_nxt.first_clear = pos[ssb_pkg::FIRST_W-1:0];
          state_nxt           = ST_IDLE;
        end else if (last_word) begin
          out_strobe_nxt  = 1'b1;
          res_nxt.all_set = 1'b1;
          state_nxt       = ST_IDLE;
        end else begin
          mem_en   = 1'b1;
          mem_addr = addr_r + 1'b1;
          addr_nxt = addr_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLR;
      addr_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      addr_r       <= addr_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    is_mark_r <= is_mark_nxt;
    sel_r     <= sel_nxt;
    res_r     <= res_nxt;
  end

endmodule

>>> dv/seen_bitmap_checker.sv
`timescale 1ns / 100ps
module seen_bitmap_checker
  import ssb_pkg::*;
#(
  parameter int                MAP_BITS  = MAP_BITS_DEF,
  parameter logic [APB_AW-1:0] SIZE_ADDR = '0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  logic [CMD_W-1:0]    in_cmd,
  input  logic [SERIAL_W-1:0] in_serial,
  input  logic                out_strobe,
  input  logic [STATUS_W-1:0] out_status,
  input  logic                out_bit_set,
  input  logic [FIRST_W-1:0]  out_first_clear,
  input  logic                out_all_set,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  input  logic                pready,
  output int                  fail_count,
  output int                  answers_pending
);

  // flat view of the store, one flag per serial number
  logic [MAP_BITS-1:0] seen_flags;
  logic [SIZE_W-1:0]   tracked_size;
  res_t                answers_owed[$];
  int                  mismatches = 0;

  assign fail_count = mismatches;

  function automatic res_t bitmap_lookup(input logic [CMD_W-1:0]    cmd,
                                         input logic [SERIAL_W-1:0] serial);
    res_t        ans;
    int unsigned lim;
    int unsigned i;
    ans = '0;
    lim = (32'(tracked_size) > MAP_BITS) ? MAP_BITS : 32'(tracked_size);
    if (cmd == CMD_TEST || cmd == CMD_MARK || cmd == CMD_FIND) begin
      if (lim == 0) begin
        ans.status = STATUS_INVALID;
      end else if (cmd == CMD_FIND) begin
        i = 0;
        while (i < lim && seen_flags[i]) i++;
        if (i == lim) ans.all_set = 1'b1;
        else ans.first_clear = i[FIRST_W-1:0];
      end else if (32'(serial) >= lim) begin
        ans.status = STATUS_RANGE;
      end else if (cmd == CMD_TEST) begin
        ans.bit_set = seen_flags[serial];
      end else begin
        seen_flags[serial] = 1'b1;
        ans.bit_set = 1'b1;
      end
    end
    return ans;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    res_t owed;
    if (!rst_n) begin
      seen_flags = '0;
      tracked_size = TRACK_SIZE_RST;
      answers_owed.delete();
    end else begin
      // retire first so a beat never meets the item accepted at this same edge
      if (out_strobe) begin
        if (answers_owed.size() == 0) begin
          $display("%0t: result beat with nothing outstanding, expected none actual status %0d",
                   $time, out_status);
          mismatches++;
        end else begin
          owed = answers_owed.pop_front();
          check_field("status", 32'(owed.status), 32'(out_status));
          check_field("bit_set", 32'(owed.bit_set), 32'(out_bit_set));
          check_field("first_clear", 32'(owed.first_clear), 32'(out_first_clear));
          check_field("all_set", 32'(owed.all_set), 32'(out_all_set));
        end
      end
      if (start && !busy) answers_owed.push_back(bitmap_lookup(in_cmd, in_serial));
      if (psel && penable && pwrite && pready && paddr == SIZE_ADDR)
        tracked_size = pwdata[SIZE_W-1:0];
    end
    answers_pending <= answers_owed.size();
  end

endmodule

>>> dv/tb_sequence_seen_bitmap_top.sv
`timescale 1ns / 100ps
module tb_sequence_seen_bitmap_top;
  import ssb_pkg::*;

  localparam int                MAP_BITS        = MAP_BITS_DEF;
  localparam logic [APB_AW-1:0] ADDR_TRACK_SIZE = '0;
  // the fourth command code has no function and must answer ok with zeros
  localparam logic [CMD_W-1:0]  CMD_UNUSED    = 2'd3;
  localparam int unsigned       SERIAL_MAX    = (1 << SERIAL_W) - 1;
  localparam int unsigned       SIZE_MAX      = (1 << SIZE_W) - 1;
  localparam int                RANDOM_BEATS  = 800;
  // worst case is a full-map scan per beat plus sender gaps, taken several times over
  localparam int                CYCLE_LIMIT   = 1000000;
  // a full scan plus margin, so a stray late beat still shows up
  localparam int                DRAIN_CYCLES  = 2 * ((MAP_BITS + 7) / 8) + 8;

  // all block inputs start at known values
  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                start     = 1'b0;
  logic [CMD_W-1:0]    in_cmd    = CMD_TEST;
  logic [SERIAL_W-1:0] in_serial = '0;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [APB_AW-1:0]   paddr     = ADDR_TRACK_SIZE;
  logic [APB_DW-1:0]   pwdata    = '0;

  logic                busy;
  logic                out_strobe;
  logic [STATUS_W-1:0] out_status;
  logic                out_bit_set;
  logic [FIRST_W-1:0]  out_first_clear;
  logic                out_all_set;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  int          fail_count;
  int          answers_pending;
  int          cycle_count = 0;

  // sender bookkeeping
  int unsigned burst_left   = 0;
  int unsigned fill_next    = 0;   // serials below this were marked in order
  int unsigned current_size = TRACK_SIZE_RST;
  int unsigned random_beats = 0;
  int unsigned sizes_written = 0;
  int unsigned n_test = 0, n_mark = 0, n_find = 0, n_unused = 0;

  always #5 clk = ~clk;

  sequence_seen_bitmap_top #(.MAP_BITS(MAP_BITS)) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_serial       (in_serial),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_bit_set     (out_bit_set),
    .out_first_clear (out_first_clear),
    .out_all_set     (out_all_set),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  seen_bitmap_checker #(.MAP_BITS(MAP_BITS), .SIZE_ADDR(ADDR_TRACK_SIZE)) u_bitmap_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_serial       (in_serial),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_bit_set     (out_bit_set),
    .out_first_clear (out_first_clear),
    .out_all_set     (out_all_set),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .fail_count      (fail_count),
    .answers_pending (answers_pending)
  );

  // watchdog: a hung handshake or a missing beat ends here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("run stopped after %0d cycles with %0d beats outstanding",
               cycle_count, answers_pending);
      $display("Verification failed");
      $finish;
    end
  end

  // one command beat; called at a rising edge, returns at the accepting edge
  task automatic issue(input logic [CMD_W-1:0] cmd, input int unsigned serial);
    int unsigned gap;
    // bursts of random length; start only drops when a real gap follows,
    // so back-to-back beats keep start high without a same-step toggle
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 60 : 12);
      gap = $urandom_range(1, 8);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    start     <= 1'b1;
    in_cmd    <= cmd;
    in_serial <= serial[SERIAL_W-1:0];
    do begin
      @(posedge clk);
    end while (busy);
    case (cmd)
      CMD_TEST: n_test++;
      CMD_MARK: n_mark++;
      CMD_FIND: n_find++;
      default: n_unused++;
    endcase
  endtask

  // register write, only once every outstanding beat has come back
  task automatic set_track_size(input int unsigned size);
    logic [31:0] junk;
    junk = $urandom();
    start <= 1'b0;
    @(posedge clk);
    while (answers_pending != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
    // setup phase; upper data bits carry noise the register must drop
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_TRACK_SIZE;
    pwdata  <= {junk[APB_DW-1:SIZE_W], size[SIZE_W-1:0]};
    @(posedge clk);
    // access phase
    penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    current_size = size & SIZE_MAX;
    sizes_written++;
  endtask

  // one phase of random beats at the current size
  task automatic random_phase(input int unsigned beats);
    int unsigned      lim, pick, serial;
    logic [31:0]      roll;
    logic [CMD_W-1:0] cmd;
    lim = (current_size > MAP_BITS) ? MAP_BITS : current_size;
    repeat (beats) begin
      pick = $urandom_range(0, 99);
      roll = $urandom();
      if (lim == 0) begin
        // invalid map: any command, any serial
        cmd = roll[CMD_W-1:0];
        serial = $urandom_range(0, SERIAL_MAX);
      end else if (pick < 60) begin
        // in-order fill keeps pushing the lowest clear serial upward
        cmd = CMD_MARK;
        if (fill_next < lim) begin
          serial = fill_next;
          fill_next++;
        end else begin
          serial = $urandom_range(0, lim - 1);
        end
      end else if (pick < 75) begin
        cmd = CMD_FIND;
        serial = $urandom_range(0, SERIAL_MAX);
      end else if (pick < 88) begin
        cmd = CMD_TEST;
        serial = (roll[8:7] == 2'b00) ? lim - 1 : $urandom_range(0, lim - 1);
      end else if (pick < 96) begin
        // out of range, often right at the boundary
        cmd = roll[4] ? CMD_MARK : CMD_TEST;
        serial = (roll[6:5] == 2'b00) ? lim : $urandom_range(lim, SERIAL_MAX);
      end else begin
        cmd = CMD_UNUSED;
        serial = $urandom_range(0, SERIAL_MAX);
      end
      issue(cmd, serial);
      if (lim != 0 && cmd != CMD_UNUSED) random_beats++;
    end
  endtask

  initial begin
    int unsigned pick, step, next_size, beats;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty map at reset size, both ends of the range
    issue(CMD_FIND, 0);
    issue(CMD_TEST, 0);
    issue(CMD_TEST, MAP_BITS - 1);
    issue(CMD_TEST, MAP_BITS);
    issue(CMD_TEST, SERIAL_MAX);
    issue(CMD_MARK, 0);
    issue(CMD_TEST, 0);
    issue(CMD_FIND, SERIAL_MAX);
    issue(CMD_MARK, MAP_BITS - 1);
    issue(CMD_TEST, MAP_BITS - 1);
    issue(CMD_MARK, SERIAL_MAX);
    issue(CMD_UNUSED, SERIAL_MAX);
    issue(CMD_UNUSED, 0);
    fill_next = 1;

    // size zero: invalid map wins over range, unused code still answers ok
    set_track_size(0);
    issue(CMD_TEST, 5);
    issue(CMD_MARK, 5);
    issue(CMD_FIND, 0);
    issue(CMD_UNUSED, 5);

    // size above capacity clamps; marks made before the zero size survive
    set_track_size(SIZE_MAX);
    issue(CMD_TEST, MAP_BITS - 1);
    issue(CMD_TEST, MAP_BITS);
    issue(CMD_FIND, 0);

    // single-bit map already full
    set_track_size(1);
    issue(CMD_FIND, 0);
    issue(CMD_TEST, 1);
    issue(CMD_TEST, 0);

    // random phases, each at a fresh size
    while (random_beats < RANDOM_BEATS) begin
      pick = $urandom_range(0, 99);
      step = $urandom_range(1, 48);
      if (pick < 45) begin
        // just past the fill point, so finds land near the top
        next_size = (fill_next + step >= MAP_BITS) ? MAP_BITS : fill_next + step;
      end else if (pick < 55) begin
        // at or below the fill point: every tracked bit set
        next_size = (fill_next == 0) ? 1 : $urandom_range(1, fill_next);
      end else if (pick < 63) begin
        next_size = MAP_BITS;
      end else if (pick < 70) begin
        next_size = ($urandom_range(0, 2) == 0) ? SIZE_MAX : $urandom_range(MAP_BITS + 1, SIZE_MAX);
      end else if (pick < 76) begin
        next_size = 0;
      end else if (pick < 84) begin
        next_size = 1;
      end else begin
        next_size = $urandom_range(1, MAP_BITS);
      end
      beats = (next_size == 0) ? $urandom_range(6, 12) : $urandom_range(15, 50);
      set_track_size(next_size);
      random_phase(beats);
    end

    // drain: every beat back, then a quiet stretch for anything extra
    start <= 1'b0;
    @(posedge clk);
    while (answers_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d commands (%0d test, %0d mark, %0d find, %0d unused) over %0d sizes",
             n_test + n_mark + n_find + n_unused, n_test, n_mark, n_find, n_unused,
             sizes_written);
    $display("in-order fill marked serials 0 to %0d", fill_next - 1);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
